>>> hw/rtl/gcd_pkg.sv
package gcd_pkg;

  // Fixed-point layout of the angle inputs: degrees times 2^ANGLE_FRAC_BITS.
  localparam int ANGLE_FRAC_BITS = 20;
  localparam int CORDIC_STAGES_DEF = 24;

  // Width of an angle after the longitude difference, sign-extended.
  localparam int ANG_W = 31;

  // One turn, half and quarter turn in input angle units.
  localparam int FULL_TURN = 360 * (2 ** ANGLE_FRAC_BITS);
  localparam int HALF_TURN = 180 * (2 ** ANGLE_FRAC_BITS);
  localparam int QUARTER_TURN = 90 * (2 ** ANGLE_FRAC_BITS);

  // Magnitude of a folded angle, at most a quarter turn.
  localparam int MAG_W = $clog2(QUARTER_TURN + 1);

  // CORDIC datapath widths: x and y in Q30 with headroom, z in Q30 radians.
  localparam int XY_W = 35;
  localparam int Z_W = 34;

  // Square root cells: one root bit per cell over a 64-bit radicand.
  localparam int SQ_RAD_W = 64;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W = SQ_ROOT_W + 4;
  localparam int SQRT_CELLS = SQ_ROOT_W;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [XY_W-1:0] GAIN_INV_Q30 = 35'sh026DD3B6A;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  // Arctangent of 2^-idx in Q30 radians.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    case (idx)
      0: return 34'sh03243F6A8;
      1: return 34'sh01DAC6705;
      2: return 34'sh00FADBAFC;
      3: return 34'sh007F56EA6;
      4: return 34'sh003FEAB76;
      5: return 34'sh001FFD55B;
      6: return 34'sh000FFFAAA;
      7: return 34'sh0007FFF55;
      8: return 34'sh0003FFFEA;
      9: return 34'sh0001FFFFD;
      10: return 34'sh0000FFFFF;
      11: return 34'sh00007FFFF;
      12: return 34'sh00003FFFF;
      13: return 34'sh00001FFFF;
      14: return 34'sh00000FFFF;
      15: return 34'sh000007FFF;
      16: return 34'sh000003FFF;
      17: return 34'sh000001FFF;
      18: return 34'sh000000FFF;
      19: return 34'sh0000007FF;
      20: return 34'sh0000003FF;
      21: return 34'sh0000001FF;
      22: return 34'sh0000000FF;
      23: return 34'sh00000007F;
      24: return 34'sh00000003F;
      25: return 34'sh00000001F;
      26: return 34'sh00000000F;
      27: return 34'sh000000008;
      28: return 34'sh000000004;
      29: return 34'sh000000002;
      30: return 34'sh000000001;
      default: return '0;
    endcase
  endfunction

endpackage

>>> hw/rtl/gcd_reduce.sv
module gcd_reduce (
  input  logic                              clk,
  input  logic signed [gcd_pkg::ANG_W-1:0]  angle,
  output logic signed [gcd_pkg::Z_W-1:0]    theta,
  output logic                              flip
);

  localparam int RW = $clog2(gcd_pkg::FULL_TURN);
  localparam int MW = gcd_pkg::MAG_W;
  localparam int QW = 31;
  // The half-turn scale 180 * 2^ANGLE_FRAC_BITS is 45 * 2^(ANGLE_FRAC_BITS + 2).
  localparam int DEG_SHIFT = gcd_pkg::ANGLE_FRAC_BITS + 2;
  localparam int NQ_W = MW + 32 - DEG_SHIFT;
  // Reciprocal of 45 scaled by 2^43, rounded up; exact for every dividend below 2^37.
  localparam int RECIP_W = 38;
  localparam int RECIP_SHIFT = 43;
  localparam logic [RECIP_W-1:0] RECIP = 38'd195468733827;
  localparam logic [18:0] RECIP_LO = RECIP[18:0];
  localparam logic [18:0] RECIP_HI = RECIP[37:19];

  localparam logic signed [gcd_pkg::ANG_W-1:0] FULL_S = gcd_pkg::ANG_W'(gcd_pkg::FULL_TURN);
  localparam logic signed [gcd_pkg::ANG_W-1:0] TWO_FULL_S =
    gcd_pkg::ANG_W'(2 * gcd_pkg::FULL_TURN);
  localparam logic [RW-1:0] FULL_U = RW'(gcd_pkg::FULL_TURN);
  localparam logic [RW-1:0] HALF_U = RW'(gcd_pkg::HALF_TURN);
  localparam logic [RW-1:0] QUARTER_U = RW'(gcd_pkg::QUARTER_TURN);
  localparam logic [RW-1:0] THREE_Q_U = RW'(gcd_pkg::FULL_TURN - gcd_pkg::QUARTER_TURN);

  logic signed [gcd_pkg::ANG_W-1:0] wrap;
  logic [RW-1:0] r1;
  logic [MW-1:0] mag2;
  logic neg2, flip2;
  logic [MW+31:0] prod3;
  logic [NQ_W-1:0] pq;
  logic neg3, flip3;
  logic [18:0] pq_lo;
  logic [17:0] pq_hi;
  logic [37:0] p_ll, p_lh;
  logic [36:0] p_hl, p_hh;
  logic neg4, flip4;
  logic [74:0] total;
  logic [QW-1:0] q5;
  logic neg5, flip5;
  logic [gcd_pkg::Z_W-1:0] qx;

  // Wrap the angle into one turn, from zero up.
  always_comb begin
    if (angle < -FULL_S) begin
      wrap = angle + TWO_FULL_S;
    end else if (angle < 0) begin
      wrap = angle + FULL_S;
    end else if (angle < FULL_S) begin
      wrap = angle;
    end else begin
      wrap = angle - FULL_S;
    end
  end

  always_ff @(posedge clk) begin
    r1 <= wrap[RW-1:0];
  end

  // Fold into a quarter turn, keeping the sign and whether the cosine flips.
  always_ff @(posedge clk) begin
    if (r1 <= QUARTER_U) begin
      mag2 <= MW'(r1);
      neg2 <= 1'b0;
      flip2 <= 1'b0;
    end else if (r1 < HALF_U) begin
      mag2 <= MW'(HALF_U - r1);
      neg2 <= 1'b0;
      flip2 <= 1'b1;
    end else if (r1 < THREE_Q_U) begin
      mag2 <= MW'(r1 - HALF_U);
      neg2 <= 1'b1;
      flip2 <= 1'b1;
    end else begin
      mag2 <= MW'(FULL_U - r1);
      neg2 <= 1'b1;
      flip2 <= 1'b0;
    end
  end

  // Scale by pi and drop the power-of-two part of the half-turn scale.
  assign prod3 = mag2 * gcd_pkg::PI_Q30;

  always_ff @(posedge clk) begin
    pq <= prod3[MW+31:DEG_SHIFT];
    neg3 <= neg2;
    flip3 <= flip2;
  end

  // Divide by 45 through the reciprocal, as four partial products.
  assign pq_lo = pq[18:0];
  assign pq_hi = pq[NQ_W-1:19];

  always_ff @(posedge clk) begin
    p_ll <= pq_lo * RECIP_LO;
    p_lh <= pq_lo * RECIP_HI;
    p_hl <= pq_hi * RECIP_LO;
    p_hh <= pq_hi * RECIP_HI;
    neg4 <= neg3;
    flip4 <= flip3;
  end

  assign total = 75'(p_ll) + (75'(p_lh) << 19) + (75'(p_hl) << 19) + (75'(p_hh) << 38);

  always_ff @(posedge clk) begin
    q5 <= total[RECIP_SHIFT+QW-1:RECIP_SHIFT];
    neg5 <= neg4;
    flip5 <= flip4;
  end

  // Reapply the sign to get radians in Q30.
  assign qx = {{(gcd_pkg::Z_W-QW){1'b0}}, q5};

  always_ff @(posedge clk) begin
    theta <= neg5 ? -qx : qx;
    flip <= flip5;
  end

endmodule

>>> hw/rtl/gcd_cordic_cell.sv
module gcd_cordic_cell #(
  parameter int SHIFT = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                             clk,
  input  logic signed [gcd_pkg::XY_W-1:0]  x_in,
  input  logic signed [gcd_pkg::XY_W-1:0]  y_in,
  input  logic signed [gcd_pkg::Z_W-1:0]   z_in,
  output logic signed [gcd_pkg::XY_W-1:0]  x_out,
  output logic signed [gcd_pkg::XY_W-1:0]  y_out,
  output logic signed [gcd_pkg::Z_W-1:0]   z_out
);

  localparam logic signed [gcd_pkg::Z_W-1:0] ATAN = gcd_pkg::atan_q30(SHIFT);

  logic signed [gcd_pkg::XY_W-1:0] xs, ys;
  logic dir;

  // Rotation steers by the residual angle, vectoring by the sign of y.
  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;
  assign dir = VECTORING ? y_in[gcd_pkg::XY_W-1] : ~z_in[gcd_pkg::Z_W-1];

  // One micro-rotation per cell.
  always_ff @(posedge clk) begin
    if (dir) begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ATAN;
    end else begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ATAN;
    end
  end

endmodule

>>> hw/rtl/gcd_sqrt_cell.sv
module gcd_sqrt_cell (
  input  logic                             clk,
  input  logic [gcd_pkg::SQ_REM_W-1:0]     rem_in,
  input  logic [gcd_pkg::SQ_ROOT_W-1:0]    root_in,
  input  logic [gcd_pkg::SQ_RAD_W-1:0]     rad_in,
  output logic [gcd_pkg::SQ_REM_W-1:0]     rem_out,
  output logic [gcd_pkg::SQ_ROOT_W-1:0]    root_out,
  output logic [gcd_pkg::SQ_RAD_W-1:0]     rad_out
);

  logic [gcd_pkg::SQ_REM_W-1:0] tmp, trial;
  logic ge;

  // Bring down the next two radicand bits and try a one in the root.
  assign tmp = {rem_in[gcd_pkg::SQ_REM_W-3:0], rad_in[gcd_pkg::SQ_RAD_W-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge = (tmp >= trial);

  always_ff @(posedge clk) begin
    rem_out <= ge ? tmp - trial : tmp;
    root_out <= {root_in[gcd_pkg::SQ_ROOT_W-2:0], ge};
    rad_out <= rad_in << 2;
  end

endmodule

>>> hw/rtl/great_circle_distance.sv
// Channel   Handshake                    Payload
// input     start, busy                  lat_a, lon_a, lat_b, lon_b
// result    distance_valid (strobe)      distance
// config    cfg_valid, cfg_ready         cfg_data (sphere radius)
//
// A point pair is taken in every cycle; busy is high only during reset.
// Each result passes the two CORDIC cell rows and two 32-cell square root rows.
// Reset clears the valid pipeline and loads the radius with its default.
// The receiver cannot stall: each result is shown for one cycle only.
module great_circle_distance #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  output logic               distance_valid,
  output logic [17:0]        distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int XY_W = gcd_pkg::XY_W;
  localparam int Z_W = gcd_pkg::Z_W;
  localparam int NC = gcd_pkg::SQRT_CELLS;
  localparam int LAT = 80 + 2 * CORDIC_STAGES;
  localparam int V_VEC_IN = 77 + CORDIC_STAGES;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [60:0] ONE_SQ = 61'(1) << 60;

  logic accept;
  logic [LAT-1:0] vld;
  logic [15:0] sphere_radius;

  logic signed [27:0] in_lat_a, in_lat_b;
  logic signed [29:0] in_dlon;
  logic signed [gcd_pkg::ANG_W-1:0] ang [3];
  logic signed [Z_W-1:0] theta [3];
  logic flip [3];
  logic [2:0] fl [CORDIC_STAGES];

  logic signed [XY_W-1:0] rx [3][CORDIC_STAGES+1];
  logic signed [XY_W-1:0] ry [3][CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  rz [3][CORDIC_STAGES+1];

  logic signed [31:0] sa, ca, sb, cb, sd, cd;
  logic signed [63:0] p1, p2;
  logic signed [33:0] dz_m, dx, dy, dz;
  logic signed [31:0] cb_m;
  logic signed [67:0] sqx_f, sqy_f, sqz_f;
  logic [60:0] sq_x, sq_y, sq_z;
  logic [gcd_pkg::SQ_RAD_W-1:0] sum;

  logic [gcd_pkg::SQ_REM_W-1:0]  s1_rem [NC+1];
  logic [gcd_pkg::SQ_ROOT_W-1:0] s1_root [NC+1];
  logic [gcd_pkg::SQ_RAD_W-1:0]  s1_rad [NC+1];
  logic [gcd_pkg::SQ_REM_W-1:0]  s2_rem [NC+1];
  logic [gcd_pkg::SQ_ROOT_W-1:0] s2_root [NC+1];
  logic [gcd_pkg::SQ_RAD_W-1:0]  s2_rad [NC+1];

  logic [30:0] b_next, b_reg;
  logic [60:0] bb, arg;
  logic [30:0] bd [NC+1];

  logic signed [XY_W-1:0] vx [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] vy [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  vz [CORDIC_STAGES+1];
  logic [30:0] zc;
  logic [46:0] prod;

  // Handshakes: always ready outside reset.
  assign busy = rst;
  assign cfg_ready = ~rst;
  assign accept = start & ~busy;

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sphere_radius <= cfg_data;
    end
  end

  // Valid bits follow each transaction down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // Input register, with the longitude difference.
  always_ff @(posedge clk) begin
    in_lat_a <= lat_a;
    in_lat_b <= lat_b;
    in_dlon <= 30'(lon_a) - 30'(lon_b);
  end

  assign ang[0] = gcd_pkg::ANG_W'(in_lat_a);
  assign ang[1] = gcd_pkg::ANG_W'(in_lat_b);
  assign ang[2] = gcd_pkg::ANG_W'(in_dlon);

  // Three angle lanes: reduction to radians, then a rotation cell row.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    gcd_reduce u_reduce (
      .clk   (clk),
      .angle (ang[l]),
      .theta (theta[l]),
      .flip  (flip[l])
    );

    assign rx[l][0] = gcd_pkg::GAIN_INV_Q30;
    assign ry[l][0] = '0;
    assign rz[l][0] = theta[l];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      gcd_cordic_cell #(
        .SHIFT     (i),
        .VECTORING (1'b0)
      ) u_cell (
        .clk   (clk),
        .x_in  (rx[l][i]),
        .y_in  (ry[l][i]),
        .z_in  (rz[l][i]),
        .x_out (rx[l][i+1]),
        .y_out (ry[l][i+1]),
        .z_out (rz[l][i+1])
      );
    end
  end

  // Cosine sign flips travel beside the rotation rows.
  always_ff @(posedge clk) begin
    fl[0] <= {flip[2], flip[1], flip[0]};
    for (int k = 1; k < CORDIC_STAGES; k++) begin
      fl[k] <= fl[k-1];
    end
  end

  // Sine and cosine of each lane.
  always_ff @(posedge clk) begin
    sa <= 32'(ry[0][CORDIC_STAGES]);
    sb <= 32'(ry[1][CORDIC_STAGES]);
    sd <= 32'(ry[2][CORDIC_STAGES]);
    ca <= 32'(fl[CORDIC_STAGES-1][0] ? -rx[0][CORDIC_STAGES] : rx[0][CORDIC_STAGES]);
    cb <= 32'(fl[CORDIC_STAGES-1][1] ? -rx[1][CORDIC_STAGES] : rx[1][CORDIC_STAGES]);
    cd <= 32'(fl[CORDIC_STAGES-1][2] ? -rx[2][CORDIC_STAGES] : rx[2][CORDIC_STAGES]);
  end

  // Chord vector: products, then components.
  always_ff @(posedge clk) begin
    p1 <= cd * ca;
    p2 <= sd * ca;
    dz_m <= 34'(sa) - 34'(sb);
    cb_m <= cb;
  end

  always_ff @(posedge clk) begin
    dx <= 34'(p1 >>> 30) - 34'(cb_m);
    dy <= 34'(p2 >>> 30);
    dz <= dz_m;
  end

  // Squared components, each divided by four.
  assign sqx_f = dx * dx;
  assign sqy_f = dy * dy;
  assign sqz_f = dz * dz;

  always_ff @(posedge clk) begin
    sq_x <= sqx_f[62:2];
    sq_y <= sqy_f[62:2];
    sq_z <= sqz_f[62:2];
  end

  always_ff @(posedge clk) begin
    sum <= gcd_pkg::SQ_RAD_W'(sq_x) + gcd_pkg::SQ_RAD_W'(sq_y) +
           gcd_pkg::SQ_RAD_W'(sq_z);
  end

  // Half chord length b by a square root cell row.
  assign s1_rem[0] = '0;
  assign s1_root[0] = '0;
  assign s1_rad[0] = sum;

  for (genvar i = 0; i < NC; i++) begin : g_sq1
    gcd_sqrt_cell u_cell (
      .clk      (clk),
      .rem_in   (s1_rem[i]),
      .root_in  (s1_root[i]),
      .rad_in   (s1_rad[i]),
      .rem_out  (s1_rem[i+1]),
      .root_out (s1_root[i+1]),
      .rad_out  (s1_rad[i+1])
    );
  end

  // Clamp b to one and square it.
  assign b_next = (s1_root[NC] > Q30_ONE) ? Q30_ONE[30:0] : s1_root[NC][30:0];

  always_ff @(posedge clk) begin
    b_reg <= b_next;
    bb <= b_next * b_next;
  end

  always_ff @(posedge clk) begin
    arg <= ONE_SQ - bb;
    bd[0] <= b_reg;
    for (int k = 1; k <= NC; k++) begin
      bd[k] <= bd[k-1];
    end
  end

  // h = sqrt(1 - b*b) by a second cell row.
  assign s2_rem[0] = '0;
  assign s2_root[0] = '0;
  assign s2_rad[0] = gcd_pkg::SQ_RAD_W'(arg);

  for (genvar i = 0; i < NC; i++) begin : g_sq2
    gcd_sqrt_cell u_cell (
      .clk      (clk),
      .rem_in   (s2_rem[i]),
      .root_in  (s2_root[i]),
      .rad_in   (s2_rad[i]),
      .rem_out  (s2_rem[i+1]),
      .root_out (s2_root[i+1]),
      .rad_out  (s2_rad[i+1])
    );
  end

  // Angle atan2(b, h) by a vectoring cell row.
  assign vx[0] = {3'b000, s2_root[NC]};
  assign vy[0] = {4'b0000, bd[NC]};
  assign vz[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    gcd_cordic_cell #(
      .SHIFT     (i),
      .VECTORING (1'b1)
    ) u_cell (
      .clk   (clk),
      .x_in  (vx[i]),
      .y_in  (vy[i]),
      .z_in  (vz[i]),
      .x_out (vx[i+1]),
      .y_out (vy[i+1]),
      .z_out (vz[i+1])
    );
  end

  // Scale by the radius; twice the angle is folded into the final shift.
  assign zc = vz[CORDIC_STAGES][Z_W-1] ? '0 : vz[CORDIC_STAGES][30:0];

  always_ff @(posedge clk) begin
    prod <= sphere_radius * zc;
  end

  always_ff @(posedge clk) begin
    distance <= prod[46:29];
  end

  assign distance_valid = vld[LAT-1];

  // A radius write shows in the register in the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> sphere_radius == $past(cfg_data))
    else $error("radius write lost");

  // Every result strobe traces back to a transaction a full latency earlier.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    distance_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching transaction");

  // The vectoring row sees a point inside the unit quarter circle.
  a_vec_input: assert property (@(posedge clk) disable iff (rst)
    vld[V_VEC_IN] |-> (bd[NC] <= Q30_ONE[30:0]) && (s2_root[NC] <= Q30_ONE))
    else $error("vectoring input out of range");

endmodule

>>> tb/distance_checker.sv
// Watches the pair, result and radius channels of great_circle_distance.
// It predicts each distance in fixed point and compares it with the result.
module distance_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  input  logic               distance_valid,
  input  logic [17:0]        distance,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam int STAGES = gcd_pkg::CORDIC_STAGES_DEF;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint PI_FIX = 64'sd3373259426;
  localparam longint GAIN_FIX = 64'sh26DD3B6A;
  localparam longint SAT_DIST = 64'sd262143;

  // Arctangent of 2^-i in Q30 radians.
  localparam longint ATAN_STEP [0:31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  logic [17:0] expected_dist [$];
  longint unsigned radius;

  // Integer square root, rounded down.
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Sine and cosine in Q30 of an angle given in input degree units.
  function automatic void trig_of(input longint d, output longint s, output longint c);
    longint full, half, quarter, r, theta, x, y, z, xn;
    longint unsigned mag;
    bit flip;
    full = 64'sd360 << gcd_pkg::ANGLE_FRAC_BITS;
    half = 64'sd180 << gcd_pkg::ANGLE_FRAC_BITS;
    quarter = 64'sd90 << gcd_pkg::ANGLE_FRAC_BITS;
    flip = 1'b0;
    r = d % full;
    if (r < 0) r = r + full;
    if (r >= half) r = r - full;
    if (r > quarter) begin
      r = half - r;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r = -half - r;
      flip = 1'b1;
    end
    mag = (r < 0) ? -r : r;
    theta = longint'(mag * longint'(PI_FIX) / longint'(half));
    if (r < 0) theta = -theta;
    x = GAIN_FIX;
    y = 0;
    z = theta;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_STEP[i];
      end else begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_STEP[i];
      end
      x = xn;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // Great-circle distance in radius units for one point pair.
  function automatic logic [17:0] arc_length(input longint la, input longint oa,
                                             input longint lb, input longint ob,
                                             input longint unsigned rad);
    longint sa, ca, sb, cb, sd, cd, dx, dy, dz, b, h, x, y, z, xn;
    longint unsigned sum, span;
    trig_of(la, sa, ca);
    trig_of(lb, sb, cb);
    trig_of(oa - ob, sd, cd);
    dz = sa - sb;
    dx = ((cd * ca) >>> 30) - cb;
    dy = (sd * ca) >>> 30;
    sum = longint'(dx * dx) >> 2;
    sum = sum + (longint'(dy * dy) >> 2);
    sum = sum + (longint'(dz * dz) >> 2);
    b = longint'(int_root(sum));
    if (b > ONE_Q30) b = ONE_Q30;
    h = longint'(int_root(ONE_Q30 * ONE_Q30 - b * b));
    // Vectoring rotation recovers the half angle.
    x = h;
    y = b;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_STEP[i];
      end else begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_STEP[i];
      end
      x = xn;
    end
    if (z < 0) z = 0;
    span = (64'd2 * rad * longint'(z)) >> 30;
    if (span > SAT_DIST) span = SAT_DIST;
    return span[17:0];
  endfunction

  // Track the radius, queue predictions and compare each result in order.
  always @(posedge clk) begin
    logic [17:0] want;
    if (rst) begin
      radius = gcd_pkg::RADIUS_RESET;
      expected_dist.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) radius = cfg_data;
      if (start && !busy)
        expected_dist.push_back(arc_length(lat_a, lon_a, lat_b, lon_b, radius));
      if (distance_valid) begin
        if (expected_dist.size() == 0) begin
          $display("%0t: unexpected distance %0d, expected none", $time, distance);
          errors++;
        end else begin
          want = expected_dist.pop_front();
          checked++;
          if (want !== distance) begin
            $display("%0t: distance mismatch, expected %0d, actual %0d",
                     $time, want, distance);
            errors++;
          end
        end
      end
    end
    pending = expected_dist.size();
  end

endmodule

>>> tb/testbench.sv
// Drives point pairs and radius settings into great_circle_distance.
module testbench;

  localparam longint DEG = 64'sd1 << gcd_pkg::ANGLE_FRAC_BITS;
  localparam longint LAT_LIM = 90 * DEG;
  localparam longint LON_LIM = 180 * DEG;
  localparam int DRAIN = 140;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PAIRS = 1400;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [27:0] lat_a;
  logic signed [28:0] lon_a;
  logic signed [27:0] lat_b;
  logic signed [28:0] lon_b;
  logic               distance_valid;
  logic [17:0]        distance;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;
  int                 errors;
  int                 pending;
  int                 checked;
  int                 pairs_sent;
  int                 idle_cycles;
  bit                 back_to_back;

  great_circle_distance i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .distance_valid(distance_valid), .distance(distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  distance_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .distance_valid(distance_valid), .distance(distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always #1 clk = ~clk;

  // Watchdog: end the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if ((start && !busy) || distance_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offers one pair after a gap; returns at the falling edge after acceptance.
  task automatic send_pair(input longint la, input longint oa,
                           input longint lb, input longint ob);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    lat_a <= la[27:0];
    lon_a <= oa[28:0];
    lat_b <= lb[27:0];
    lon_b <= ob[28:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pairs_sent++;
    @(negedge clk);
  endtask

  // Writes the radius once no result is outstanding and the pipeline has drained.
  task automatic set_radius(input logic [15:0] value);
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random pair: in range, full field width, nearby points or near antipodes.
  task automatic send_random_pair();
    longint la, oa, lb, ob;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      la = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      oa = $urandom_range(0, 2 * LON_LIM) - LON_LIM;
      lb = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      ob = $urandom_range(0, 2 * LON_LIM) - LON_LIM;
    end else if (kind < 7) begin
      la = longint'($signed($urandom() & 32'h0FFF_FFFF) <<< 4) >>> 4;
      oa = longint'($signed($urandom() & 32'h1FFF_FFFF) <<< 3) >>> 3;
      lb = longint'($signed($urandom() & 32'h0FFF_FFFF) <<< 4) >>> 4;
      ob = longint'($signed($urandom() & 32'h1FFF_FFFF) <<< 3) >>> 3;
    end else if (kind < 9) begin
      la = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      oa = $urandom_range(0, 2 * LON_LIM) - LON_LIM;
      lb = la + $urandom_range(0, 4000) - 2000;
      ob = oa + $urandom_range(0, 4000) - 2000;
      if (lb > LAT_LIM || lb < -LAT_LIM) lb = la;
      if (ob > LON_LIM || ob < -LON_LIM) ob = oa;
    end else begin
      la = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      oa = $urandom_range(0, LON_LIM);
      lb = -la + $urandom_range(0, 200) - 100;
      ob = oa - LON_LIM + $urandom_range(0, 200) - 100;
      if (lb > LAT_LIM || lb < -LAT_LIM) lb = -la;
    end
    send_pair(la, oa, lb, ob);
  endtask

  initial begin
    logic [15:0] radii [0:5];
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    lat_a = '0;
    lon_a = '0;
    lat_b = '0;
    lon_b = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    pairs_sent = 0;
    back_to_back = 1'b0;
    radii = '{16'd65535, 16'd1, 16'd0, 16'd6371, 16'd0, 16'd0};
    radii[4] = $urandom_range(1, 65535);
    radii[5] = $urandom_range(1, 1000);
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pairs at the reset radius: same point, poles, antipodes,
    // longitude wrap, latitudes past the poles and the field extremes.
    send_pair(0, 0, 0, 0);
    send_pair(LAT_LIM, 0, -LAT_LIM, 0);
    send_pair(LAT_LIM, 12345, LAT_LIM, -LON_LIM);
    send_pair(0, 0, 0, LON_LIM);
    send_pair(0, -LON_LIM, 0, LON_LIM);
    send_pair(0, LON_LIM, 0, -LON_LIM + DEG);
    send_pair(45 * DEG, 90 * DEG, -45 * DEG, -90 * DEG);
    send_pair(10 * DEG, 20 * DEG, 10 * DEG, 20 * DEG + 1);
    send_pair(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM);
    send_pair(134217727, 268435455, -134217728, -268435456);
    send_pair(-134217728, -268435456, 134217727, 268435455);
    send_pair(120 * DEG, 0, 60 * DEG, 0);
    send_pair(-100 * DEG, 200 * DEG, 30 * DEG, -170 * DEG);
    send_pair(1, 1, -1, -1);
    send_pair(LAT_LIM - 1, 0, -LAT_LIM + 1, LON_LIM - 1);

    // Radius phases, extremes and zero among them, each with random pairs.
    for (int p = 0; p < 6; p++) begin
      set_radius(radii[p]);
      for (int n = 0; n < RANDOM_PAIRS / 6; n++) begin
        if (n % 40 == 0) back_to_back = ($urandom_range(0, 3) == 0);
        send_random_pair();
      end
      back_to_back = 1'b0;
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    $display("Sent %0d point pairs and checked %0d distances.", pairs_sent, checked);
    $display("Radius settings covered: reset value plus six written, zero and 65535 included.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
